@@ hw/rtl/rtla_pkg.sv @@
package rtla_pkg;

  localparam int KEY_BITS      = 32;
  localparam int BYTE_BITS     = 8;
  localparam int IN_DATA_BITS  = 64;
  localparam int OUT_DATA_BITS = 32;

  localparam logic [1:0] LAST_PTR_LEVEL = 2'd2;
  localparam logic [1:0] PTR_LEVELS     = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_ALLOC,
    ST_LEAF_READ,
    ST_LEAF_EVAL,
    ST_FINISH
  } state_t;

  function automatic logic [BYTE_BITS-1:0] key_byte(input logic [KEY_BITS-1:0] key,
                                                    input logic [1:0] lvl);
    logic [BYTE_BITS-1:0] b;
    case (lvl)
      2'd0: b = key[31:24];
      2'd1: b = key[23:16];
      2'd2: b = key[15:8];
      default: b = key[7:0];
    endcase
    return b;
  endfunction

endpackage

@@ hw/rtl/rtla_ram.sv @@
module rtla_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ hw/rtl/radix_table_lookup_allocate.sv @@
// Sparse map from a 32-bit key to a value, kept as a four-level radix table of
// 256-way nodes drawn from a pool of NODE_COUNT nodes in one single-port memory.
// Key bytes three to one pick pointer entries, byte zero picks the leaf slot,
// and missing nodes are allocated on the way down for reads and writes alike.
// Each item returns the slot's earlier value; a write then stores the new one.
// If the pool cannot supply every missing node, nothing changes and the item
// returns zero with status set. After reset the block clears every word of the
// memory before it accepts its first item. On a path that already exists, each
// pointer level takes a read and an evaluation step, followed by a leaf read,
// a leaf evaluation that stores a write's value, and a finish step. The first
// missing level adds an allocation step after its read and evaluation; each
// further missing level takes only an allocation step. An item dropped for lack
// of nodes ends as soon as the first missing level is found. A result waiting
// at the output holds the block in its last step until it is taken. The pointer
// reads, allocation writes and leaf access all share the single memory port.
module radix_table_lookup_allocate
  import rtla_pkg::*;
#(
  parameter int NODE_COUNT = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,  // key[31:0], write_value[63:32]
  input  logic                     s_axis_tuser,  // op
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata,  // read_value[31:0]
  output logic                     m_axis_tuser   // status
);

  localparam int STORE_DEPTH = NODE_COUNT * 256;
  localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
  localparam int NODE_BITS   = $clog2(NODE_COUNT);
  localparam int FREE_BITS   = $clog2(NODE_COUNT + 1);
  localparam int DATA_BITS   = (VALUE_BITS > NODE_BITS) ? VALUE_BITS : NODE_BITS;

  state_t state, state_next;

  logic [ADDR_BITS-1:0]  clear_addr;
  logic [1:0]            lvl;
  logic [NODE_BITS-1:0]  node;
  logic [FREE_BITS-1:0]  next_free;
  logic [KEY_BITS-1:0]   key;
  logic                  op;
  logic [VALUE_BITS-1:0] value;

  logic [OUT_DATA_BITS-1:0] res_value;
  logic                     res_status;

  logic                  ram_we;
  logic [ADDR_BITS-1:0]  ram_addr;
  logic [DATA_BITS-1:0]  ram_wdata;
  logic [DATA_BITS-1:0]  ram_rdata;

  logic                  child_ok;
  logic                  pool_short;
  logic                  out_free;
  logic [63:0]           wv_wide;
  logic [63:0]           old_wide;
  logic [FREE_BITS+1:0]  need;

  rtla_ram #(
    .WIDTH(DATA_BITS),
    .DEPTH(STORE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign wv_wide  = {32'd0, s_axis_tdata[63:32]};
  assign old_wide = 64'(ram_rdata[VALUE_BITS-1:0]);
  assign child_ok = (ram_rdata != '0) &&
                    ({1'b0, ram_rdata} < (DATA_BITS+1)'(NODE_COUNT));
  assign need     = (FREE_BITS+2)'(next_free) + (FREE_BITS+2)'(PTR_LEVELS - lvl);
  assign pool_short = need > (FREE_BITS+2)'(NODE_COUNT);
  assign out_free = !m_axis_tvalid || m_axis_tready;

  assign s_axis_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clear_addr == ADDR_BITS'(STORE_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_EVAL;
      ST_EVAL: begin
        if (child_ok) begin
          state_next = (lvl == LAST_PTR_LEVEL) ? ST_LEAF_READ : ST_READ;
        end else if (pool_short) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_ALLOC;
        end
      end
      ST_ALLOC: begin
        if (lvl == LAST_PTR_LEVEL) begin
          state_next = ST_LEAF_READ;
        end
      end
      ST_LEAF_READ: state_next = ST_LEAF_EVAL;
      ST_LEAF_EVAL: state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = {node, key_byte(key, lvl)};
    ram_wdata = '0;
    case (state)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clear_addr;
      end
      ST_ALLOC: begin
        ram_we    = 1'b1;
        ram_wdata = DATA_BITS'(next_free[NODE_BITS-1:0]);
      end
      ST_LEAF_READ: ram_addr = {node, key[7:0]};
      ST_LEAF_EVAL: begin
        ram_we    = op;
        ram_addr  = {node, key[7:0]};
        ram_wdata = DATA_BITS'(value);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clear_addr    <= '0;
      next_free     <= FREE_BITS'(1);
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_FINISH && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: clear_addr <= clear_addr + ADDR_BITS'(1);
        ST_IDLE: begin
          key   <= s_axis_tdata[31:0];
          op    <= s_axis_tuser;
          value <= wv_wide[VALUE_BITS-1:0];
          lvl   <= '0;
          node  <= '0;
        end
        ST_EVAL: begin
          if (child_ok) begin
            node <= ram_rdata[NODE_BITS-1:0];
            lvl  <= lvl + 2'd1;
          end else if (pool_short) begin
            res_value  <= '0;
            res_status <= 1'b1;
          end
        end
        ST_ALLOC: begin
          node      <= next_free[NODE_BITS-1:0];
          next_free <= next_free + FREE_BITS'(1);
          lvl       <= lvl + 2'd1;
        end
        ST_LEAF_EVAL: begin
          res_value  <= old_wide[OUT_DATA_BITS-1:0];
          res_status <= 1'b0;
        end
        ST_FINISH: begin
          if (out_free) begin
            m_axis_tdata  <= res_value;
            m_axis_tuser  <= res_status;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/rtla_checker.sv @@
module rtla_checker
  import rtla_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     s_axis_tvalid,
  input logic                     s_axis_tready,
  input logic                     m_axis_tvalid,
  input logic                     m_axis_tready,
  input logic [OUT_DATA_BITS-1:0] m_axis_tdata,
  input logic                     m_axis_tuser
);

  // The block works on one item at a time, so it is busy right after an accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after an accepted item");

  // A new result only appears at the end of an item's work.
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared while the block was idle");

  // A dropped access returns zero.
  a_dropped_is_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("pool exhausted result carries nonzero data");

  // A stalled result holds.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind radix_table_lookup_allocate rtla_checker u_rtla_checker (.*);
